// ----- src/mbtfc_pkg.sv -----
package mbtfc_pkg;

  localparam logic [15:0] MAX_LEN_RESET = 16'd300;
  localparam logic [7:0]  FC_BASE_MASK  = 8'h7F;
  localparam logic [7:0]  FC_EXC_FLAG   = 8'h80;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;

  // header byte layout: transaction id, protocol id, length
  localparam int unsigned HDR_BYTES  = 6;
  localparam int unsigned LEAD_BYTES = 5;
  localparam logic [15:0] POS_UNIT   = 16'd6;
  localparam logic [15:0] POS_FUNC   = 16'd7;
  localparam logic [15:0] POS_PDU    = 16'd8;
  localparam logic [15:0] MIN_FRAME  = 16'd8;

  // function codes
  localparam logic [6:0] FC_RD_COILS      = 7'h01;
  localparam logic [6:0] FC_READ_INPUTS   = 7'h04;
  localparam logic [6:0] FC_WRITE_COIL    = 7'h05;
  localparam logic [6:0] FC_WRITE_REG     = 7'h06;
  localparam logic [6:0] FC_WRITE_COILS   = 7'h0F;
  localparam logic [6:0] FC_WRITE_REGS    = 7'h10;
  localparam logic [6:0] FC_NONE          = 7'h00;

  typedef enum logic [3:0] {
    FK_REJECT,
    FK_EXC,
    FK_EXC_NO_CODE,
    FK_RD_REQ,
    FK_RD_RSP,
    FK_RD_BAD,
    FK_WR1_OK,
    FK_WR1_BAD,
    FK_WRN_RSP,
    FK_WRN_REQ,
    FK_WRN_BAD,
    FK_OTHER
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    frame_kind_t frame_kind;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [6:0]  func_code;
    logic [7:0]  exc_code;
    logic [15:0] start_address;
    logic [15:0] count_or_value;
    logic [7:0]  data_byte_count;
    logic [15:0] header_length;
    logic        length_mismatch;
    logic        byte_count_mismatch;
  } out_item_t;

  // captured frame handed from capture to classifier
  typedef struct packed {
    logic [15:0] total;
    logic [47:0] hdr;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [39:0] lead;
  } frame_snap_t;

endpackage

// ----- src/mbtfc_capture.sv -----
module mbtfc_capture import mbtfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  input  logic        snap_adv,
  output logic        snap_v,
  output frame_snap_t snap
);

  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic [47:0] hdr_r, hdr_nxt;
  logic [7:0]  unit_r, unit_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [39:0] lead_r, lead_nxt;
  logic        snap_v_r, snap_v_nxt;
  frame_snap_t snap_r;
  logic        accept;
  logic        accept_last;

  assign in_ready    = !snap_v_r || snap_adv;
  assign accept      = in_valid && in_ready;
  assign accept_last = accept && in_item.last_byte;

  always_comb begin
    hdr_nxt  = hdr_r;
    unit_nxt = unit_r;
    func_nxt = func_r;
    lead_nxt = lead_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (bytes_seen_r == 16'(i)) hdr_nxt[(HDR_BYTES-1-i)*8 +: 8] = in_item.data_byte;
    end
    if (bytes_seen_r == POS_UNIT) unit_nxt = in_item.data_byte;
    if (bytes_seen_r == POS_FUNC) func_nxt = in_item.data_byte;
    for (int i = 0; i < LEAD_BYTES; i++) begin
      if (bytes_seen_r == POS_PDU + 16'(i)) begin
        lead_nxt[(LEAD_BYTES-1-i)*8 +: 8] = in_item.data_byte;
      end
    end
    bytes_seen_nxt = (bytes_seen_r == CNT_MAX) ? bytes_seen_r : bytes_seen_r + 16'd1;
  end

  always_comb begin
    if (accept_last) begin
      snap_v_nxt = 1'b1;
    end else if (snap_adv) begin
      snap_v_nxt = 1'b0;
    end else begin
      snap_v_nxt = snap_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      hdr_r        <= '0;
      unit_r       <= '0;
      func_r       <= '0;
      lead_r       <= '0;
      snap_v_r     <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      if (accept_last) begin
        bytes_seen_r <= '0;
        hdr_r        <= '0;
        unit_r       <= '0;
        func_r       <= '0;
        lead_r       <= '0;
      end else if (accept) begin
        bytes_seen_r <= bytes_seen_nxt;
        hdr_r        <= hdr_nxt;
        unit_r       <= unit_nxt;
        func_r       <= func_nxt;
        lead_r       <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_last) begin
      snap_r.total <= bytes_seen_nxt;
      snap_r.hdr   <= hdr_nxt;
      snap_r.unit  <= unit_nxt;
      snap_r.func  <= func_nxt;
      snap_r.lead  <= lead_nxt;
    end
  end

  assign snap_v = snap_v_r;
  assign snap   = snap_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept_last |=> (snap_v_r && bytes_seen_r == 16'd0))
    else $error("frame end did not load snapshot and clear counter");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_item.last_byte && bytes_seen_r != CNT_MAX)
      |=> bytes_seen_r == $past(bytes_seen_r) + 16'd1)
    else $error("byte counter did not advance");

endmodule

// ----- src/mbtfc_classify.sv -----
module mbtfc_classify import mbtfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_v,
  input  frame_snap_t snap,
  input  logic [15:0] max_len,
  output logic        snap_adv,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   res;
  logic [15:0] pid, hlen, size, addr, qty;
  logic [6:0]  base;
  logic [7:0]  pdu0, pdu4;

  assign snap_adv = !out_valid_r || out_ready;

  assign pid  = snap.hdr[31:16];
  assign hlen = snap.hdr[15:0];
  assign base = snap.func[6:0] & FC_BASE_MASK[6:0];
  assign size = snap.total - MIN_FRAME;
  assign addr = snap.lead[39:24];
  assign qty  = snap.lead[23:8];
  assign pdu0 = snap.lead[39:32];
  assign pdu4 = snap.lead[7:0];

  always_comb begin
    res = '0;
    if (!(snap.total < MIN_FRAME || pid != 16'd0 || hlen > max_len || base == FC_NONE)) begin
      res.trans_id       = snap.hdr[47:32];
      res.unit_id        = snap.unit;
      res.func_code      = base;
      res.header_length  = hlen;
      // total is at least 8 here, so total - 6 cannot wrap
      res.length_mismatch = (hlen != snap.total - 16'd6);
      if ((snap.func & FC_EXC_FLAG) != 8'd0) begin
        if (size != 16'd0) begin
          res.frame_kind = FK_EXC;
          res.exc_code   = pdu0;
        end else begin
          res.frame_kind = FK_EXC_NO_CODE;
        end
      end else begin
        unique case (base) inside
          [FC_RD_COILS:FC_READ_INPUTS]: begin
            if (size == 16'd4) begin
              res.frame_kind     = FK_RD_REQ;
              res.start_address  = addr;
              res.count_or_value = qty;
            end else if (size != 16'd0 && {8'd0, pdu0} + 16'd1 == size) begin
              res.frame_kind      = FK_RD_RSP;
              res.data_byte_count = pdu0;
            end else begin
              res.frame_kind = FK_RD_BAD;
            end
          end
          FC_WRITE_COIL, FC_WRITE_REG: begin
            if (size == 16'd4) begin
              res.frame_kind     = FK_WR1_OK;
              res.start_address  = addr;
              res.count_or_value = qty;
            end else begin
              res.frame_kind = FK_WR1_BAD;
            end
          end
          FC_WRITE_COILS, FC_WRITE_REGS: begin
            if (size == 16'd4) begin
              res.frame_kind     = FK_WRN_RSP;
              res.start_address  = addr;
              res.count_or_value = qty;
            end else if (size >= 16'd5) begin
              res.frame_kind          = FK_WRN_REQ;
              res.start_address       = addr;
              res.count_or_value      = qty;
              res.data_byte_count     = pdu4;
              res.byte_count_mismatch = (size != {8'd0, pdu4} + 16'd5);
            end else begin
              res.frame_kind = FK_WRN_BAD;
            end
          end
          default: res.frame_kind = FK_OTHER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_adv) begin
      out_valid_r <= snap_v;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv && snap_v) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.frame_kind == FK_REJECT)
      |-> (out_item_r.trans_id == 16'd0 && out_item_r.header_length == 16'd0
           && out_item_r.unit_id == 8'd0 && !out_item_r.length_mismatch))
    else $error("rejected frame carries nonzero fields");

  a_snap_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_adv && snap_v) |=> out_valid_r)
    else $error("snapshot taken but no result presented");

endmodule

// ----- src/modbus_tcp_frame_classifier.sv -----
// channel  ports                           handshake          payload
// in       in_valid in_ready in_item       valid/ready        in_item_t (byte, last mark)
// out      out_valid out_ready out_item    valid/ready        out_item_t (classification)
// cfg      cfg_we cfg_wdata                write enable only  max_header_length, 16 bit
//
// One byte is taken per cycle while in_ready is high; after the last byte the result goes
// through the frame snapshot register, then classify logic into the result register.
// Synchronous active-low reset clears the frame state and sets the length limit to 300.
// A held result stalls input only once a second finished frame is waiting in the
// snapshot register; bytes of a frame still flow while a result waits.
module modbus_tcp_frame_classifier import mbtfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_len_r;
  logic        snap_v;
  logic        snap_adv;
  frame_snap_t snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  mbtfc_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .snap_adv (snap_adv),
    .snap_v   (snap_v),
    .snap     (snap)
  );

  mbtfc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_v    (snap_v),
    .snap      (snap),
    .max_len   (max_len_r),
    .snap_adv  (snap_adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mbtfc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;

  // function codes the package leaves unnamed
  localparam logic [6:0] FC_READ_DISCRETE = 7'h02;
  localparam logic [6:0] FC_READ_HOLDING  = 7'h03;
  localparam logic [6:0] FC_ENCAP         = 7'h2B;

  class frame_scoreboard;
    logic [15:0] limit;
    logic [15:0] count;
    logic [47:0] hdr;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [39:0] lead;
    out_item_t   expected_q[$];
    int          fails;
    int          frames_checked;

    function new();
      limit = MAX_LEN_RESET;
      fails = 0;
      frames_checked = 0;
      clear();
    endfunction

    function void clear();
      count = '0;
      hdr = '0;
      unit = '0;
      func = '0;
      lead = '0;
    endfunction

    function out_item_t classify();
      out_item_t   r;
      logic [6:0]  base;
      int unsigned size;
      int unsigned exp_len;
      r = '0;
      base = func[6:0];
      if (count < MIN_FRAME || hdr[31:16] != 16'd0 || hdr[15:0] > limit || base == FC_NONE)
        return r;
      size = count - 8;
      exp_len = (hdr[15:0] >= 16'd1) ? hdr[15:0] - 16'd1 : 0;
      r.trans_id = hdr[47:32];
      r.unit_id = unit;
      r.func_code = base;
      r.header_length = hdr[15:0];
      r.length_mismatch = (exp_len != int'(count) - 7);
      if ((func & FC_EXC_FLAG) != 8'd0) begin
        if (size > 0) begin
          r.frame_kind = FK_EXC;
          r.exc_code = lead[39:32];
        end else begin
          r.frame_kind = FK_EXC_NO_CODE;
        end
      end else if (base >= FC_RD_COILS && base <= FC_READ_INPUTS) begin
        if (size == 4) begin
          r.frame_kind = FK_RD_REQ;
          r.start_address = lead[39:24];
          r.count_or_value = lead[23:8];
        end else if (size >= 1 && int'(lead[39:32]) + 1 == size) begin
          r.frame_kind = FK_RD_RSP;
          r.data_byte_count = lead[39:32];
        end else begin
          r.frame_kind = FK_RD_BAD;
        end
      end else if (base == FC_WRITE_COIL || base == FC_WRITE_REG) begin
        if (size == 4) begin
          r.frame_kind = FK_WR1_OK;
          r.start_address = lead[39:24];
          r.count_or_value = lead[23:8];
        end else begin
          r.frame_kind = FK_WR1_BAD;
        end
      end else if (base == FC_WRITE_COILS || base == FC_WRITE_REGS) begin
        if (size == 4) begin
          r.frame_kind = FK_WRN_RSP;
          r.start_address = lead[39:24];
          r.count_or_value = lead[23:8];
        end else if (size >= 5) begin
          r.frame_kind = FK_WRN_REQ;
          r.start_address = lead[39:24];
          r.count_or_value = lead[23:8];
          r.data_byte_count = lead[7:0];
          r.byte_count_mismatch = (size - 5 != int'(lead[7:0]));
        end else begin
          r.frame_kind = FK_WRN_BAD;
        end
      end else begin
        r.frame_kind = FK_OTHER;
      end
      return r;
    endfunction

    function void note_byte(in_item_t it);
      int unsigned p;
      p = 32'(count);
      if (p < HDR_BYTES)
        hdr[8*(HDR_BYTES-1-p) +: 8] = it.data_byte;
      else if (p == POS_UNIT)
        unit = it.data_byte;
      else if (p == POS_FUNC)
        func = it.data_byte;
      else if (p < POS_PDU + LEAD_BYTES)
        lead[8*(POS_PDU+LEAD_BYTES-1-p) +: 8] = it.data_byte;
      if (count != CNT_MAX)
        count++;
      if (it.last_byte) begin
        expected_q = {expected_q, classify()};
        clear();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
        report($sformatf("frame %0d %s: expected %h, got %h", frames_checked, name, want, got));
    endtask

    task check_frame(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no frame pending, kind %0d", got.frame_kind));
        return;
      end
      want = expected_q.pop_front();
      cmp("frame_kind", 16'(want.frame_kind), 16'(got.frame_kind));
      cmp("trans_id", want.trans_id, got.trans_id);
      cmp("unit_id", 16'(want.unit_id), 16'(got.unit_id));
      cmp("func_code", 16'(want.func_code), 16'(got.func_code));
      cmp("exc_code", 16'(want.exc_code), 16'(got.exc_code));
      cmp("start_address", want.start_address, got.start_address);
      cmp("count_or_value", want.count_or_value, got.count_or_value);
      cmp("data_byte_count", 16'(want.data_byte_count), 16'(got.data_byte_count));
      cmp("header_length", want.header_length, got.header_length);
      cmp("length_mismatch", 16'(want.length_mismatch), 16'(got.length_mismatch));
      cmp("byte_count_mismatch", 16'(want.byte_count_mismatch),
          16'(got.byte_count_mismatch));
      frames_checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  frame_scoreboard sb;
  logic [7:0]      frame_q[];
  int              idle_pct;
  int              stall_pct;
  int              hold_left;
  int              items_sent;
  int              cycles;

  modbus_tcp_frame_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_byte(in_item);
      if (out_valid && out_ready)
        sb.check_frame(out_item);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // hlen < 0 puts the matching MBAP length; pos >= 0 forces that PDU data byte
  task automatic build_frame(input logic [7:0] fc, input int n, input int pos,
                             input logic [7:0] val, input logic [15:0] pid, input int hlen);
    logic [15:0] tid;
    logic [15:0] len;
    logic [7:0]  uid;
    tid = 16'($urandom);
    uid = 8'($urandom);
    len = (hlen < 0) ? 16'(n + 2) : 16'(hlen);
    frame_q = new[n + 8];
    frame_q[0] = tid[15:8];
    frame_q[1] = tid[7:0];
    frame_q[2] = pid[15:8];
    frame_q[3] = pid[7:0];
    frame_q[4] = len[15:8];
    frame_q[5] = len[7:0];
    frame_q[6] = uid;
    frame_q[7] = fc;
    for (int i = 0; i < n; i++)
      frame_q[8 + i] = (i == pos) ? val : 8'($urandom);
  endtask

  task automatic make_noise(input int n);
    frame_q = new[n];
    foreach (frame_q[i])
      frame_q[i] = 8'($urandom);
  endtask

  task automatic rand_frame();
    int          shape;
    int          n;
    int          pos;
    int          hlen;
    int          bc;
    logic [7:0]  fc;
    logic [7:0]  val;
    logic [15:0] pid;
    shape = $urandom_range(99);
    n = $urandom_range(8);
    pos = -1;
    hlen = -1;
    val = 8'($urandom);
    fc = 8'($urandom);
    pid = ($urandom_range(11) == 0) ? 16'($urandom_range(65535, 1)) : 16'd0;
    if (shape < 12) begin
      make_noise($urandom_range(16, 1));
    end else begin
      if (shape < 30) begin
        fc = 8'($urandom_range(FC_READ_INPUTS, FC_RD_COILS));
        case ($urandom_range(2))
          0: n = 4;
          1: begin
            bc = $urandom_range(12);
            n = bc + 1;
            pos = 0;
            val = 8'(bc);
          end
          default: ;
        endcase
      end else if (shape < 42) begin
        fc = $urandom_range(1) ? 8'(FC_WRITE_REG) : 8'(FC_WRITE_COIL);
        if ($urandom_range(1))
          n = 4;
      end else if (shape < 62) begin
        fc = $urandom_range(1) ? 8'(FC_WRITE_REGS) : 8'(FC_WRITE_COILS);
        case ($urandom_range(2))
          0: n = 4;
          1: begin
            bc = $urandom_range(10);
            n = 5 + bc;
            pos = 4;
            if ($urandom_range(3) != 0)
              val = 8'(bc);
          end
          default: ;
        endcase
      end else if (shape < 74) begin
        fc = FC_EXC_FLAG | 8'($urandom_range(127, 1));
        n = $urandom_range(2);
      end else if (shape < 88) begin
        fc = 8'($urandom_range(127));
      end
      case ($urandom_range(9))
        0: hlen = sb.limit;
        1: hlen = (int'(sb.limit) + 1) & 16'hFFFF;
        2: hlen = $urandom_range(65535);
        3: hlen = n + 1 + 2 * $urandom_range(1);
        default: ;
      endcase
      build_frame(fc, n, pos, val, pid, hlen);
    end
  endtask

  // move to new idle and stall rates and hold-off between edges so the stall process sees them cleanly
  task automatic set_rates(input int idle, input int stall, input int hold);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    hold_left = hold;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int target;
    idle_tab = '{0, 70, 0, 26};
    stall_tab = '{0, 0, 70, 26};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at the reset limit
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_READ_INPUTS), 3, 0, 8'd2, 16'd0, -1); send_frame();
    build_frame(8'(FC_READ_DISCRETE), 2, 0, 8'd5, 16'd0, -1); send_frame();
    build_frame(FC_EXC_FLAG | 8'(FC_READ_HOLDING), 1, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(FC_EXC_FLAG | 8'(FC_RD_COILS), 0, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_REG), 4, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_COIL), 2, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_REGS), 7, 4, 8'd2, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_COILS), 9, 4, 8'd2, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_COILS), 4, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_WRITE_REGS), 1, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_ENCAP), 3, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_NONE), 4, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(FC_EXC_FLAG, 1, -1, 8'd0, 16'd0, -1); send_frame();
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd1, -1); send_frame();
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, 301); send_frame();
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, 300); send_frame();
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, 0); send_frame();
    make_noise(1); send_frame();
    make_noise(7); send_frame();
    for (int v = 0; v < 2; v++) begin
      frame_q = new[13];
      foreach (frame_q[j])
        frame_q[j] = v ? 8'hFF : 8'h00;
      send_frame();
    end

    // limit of zero: only a zero length field gets through
    settle();
    write_limit(16'd0);
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, 0); send_frame();
    build_frame(8'(FC_READ_HOLDING), 4, -1, 8'd0, 16'd0, -1); send_frame();

    // widest limit
    settle();
    write_limit(16'hFFFF);
    build_frame(8'(FC_WRITE_COILS), 4, -1, 8'd0, 16'd0, 65535); send_frame();

    target = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_limit(MAX_LEN_RESET);
        1: write_limit(16'hFFFF);
        2: write_limit(16'($urandom_range(65535)));
        default: write_limit(16'($urandom_range(40, 2)));
      endcase
      // long result hold-off while bytes keep coming in the stalling phase
      set_rates(idle_tab[ph], stall_tab[ph], (ph == 2) ? 400 : 0);
      target += RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        rand_frame();
        send_frame();
        if (ph == 2 && items_sent >= target - RANDOM_ITEMS / 8 && hold_left == 0
            && sb.expected_q.size() > 1) begin
          settle();
          hold_left = 0;
        end
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (sb.fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
